### rtl/core/ppp_pkg.sv
package ppp_pkg;

	localparam int CoefW    = 32;
	localparam int HomW     = 48;
	localparam int ProjW    = 32;
	localparam int RoundW   = 50;
	localparam int DivSteps = 32;
	localparam int StepsPerStage = 2;
	localparam int DivStages = DivSteps / StepsPerStage;
	localparam int NumRegs  = 6;
	localparam int CfgW     = 64;
	localparam int CfgAddrW = 3;

	localparam logic [CfgW-1:0] CfgReset [NumRegs] = '{
		64'h0000_0000_0001_0000, 64'h0,
		64'h0001_0000_0000_0000, 64'h0,
		64'h0,                   64'h0000_0000_0001_0000
	};

	typedef struct packed {
		logic signed [CoefW-1:0] point_x;
		logic signed [CoefW-1:0] point_y;
		logic signed [CoefW-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [HomW-1:0]  hom_u;
		logic signed [HomW-1:0]  hom_v;
		logic signed [HomW-1:0]  hom_w;
		logic signed [ProjW-1:0] proj_u;
		logic signed [ProjW-1:0] proj_v;
		logic                    zero_depth;
		logic                    overflow;
	} result_t;

	// Divider lane state carried down the pipeline.
	typedef struct packed {
		logic [HomW-1:0]     hom_u;
		logic [HomW-1:0]     hom_v;
		logic [HomW-1:0]     hom_w;
		logic                hom_ovf;
		logic                zero;
		logic                neg_u;
		logic                neg_v;
		logic                big_u;
		logic                big_v;
		logic [RoundW-1:0]   ad;
		logic [RoundW-1:0]   rem_u;
		logic [RoundW-1:0]   rem_v;
		logic [DivSteps-1:0] q_u;
		logic [DivSteps-1:0] q_v;
		logic [DivSteps-1:0] bits_u;
		logic [DivSteps-1:0] bits_v;
	} div_t;

endpackage

### rtl/core/perspective_point_projection.sv
// Throughput: one point per cycle while the output is not stalled; the quotient
// is resolved two bits per stage over sixteen stages of a pair of restoring
// dividers that run side by side.
// Reset: arst_n clears all stage valid bits and restores the camera matrix to identity.
// Stalls propagate stage by stage, so empty stages keep filling while a result waits.
module perspective_point_projection (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ppp_pkg::CfgAddrW-1:0]       cfg_addr,
	input  logic [ppp_pkg::CfgW-1:0]           cfg_wdata,
	input  logic                               point_valid,
	output logic                               point_ready,
	input  ppp_pkg::point_t                    point,
	output logic                               result_valid,
	input  logic                               result_ready,
	output ppp_pkg::result_t                   result
);
	import ppp_pkg::*;

	localparam int NStg = 3 + DivStages + 2;
	localparam int DivBase = 3;
	localparam int OutIdx = NStg - 1;

	logic [CfgW-1:0] cfg_q [NumRegs];
	logic [NStg-1:0] vld_q;
	logic [NStg-1:0] adv;

	// Matrix registers: writes beyond the last index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) cfg_q[i] <= CfgReset[i];
		end else if (cfg_we && (int'(cfg_addr) < NumRegs)) begin
			cfg_q[cfg_addr] <= cfg_wdata;
		end
	end

	// Advance a stage when it is empty or the next one advances.
	always_comb begin
		adv[OutIdx] = ~vld_q[OutIdx] | result_ready;
		for (int k = OutIdx - 1; k >= 0; k--) adv[k] = ~vld_q[k] | adv[k+1];
	end
	assign point_ready  = adv[0];
	assign result_valid = vld_q[OutIdx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= point_valid;
			for (int k = 1; k < NStg; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// Stage 1: nine products; the constant column is a plain shift.
	logic signed [63:0] prod_s1 [3][4];
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[r][0] <= point.point_x * $signed(cfg_q[2*r][31:0]);
				prod_s1[r][1] <= point.point_y * $signed(cfg_q[2*r][63:32]);
				prod_s1[r][2] <= point.point_z * $signed(cfg_q[2*r+1][31:0]);
				prod_s1[r][3] <= {{16{cfg_q[2*r+1][63]}}, cfg_q[2*r+1][63:32], 16'h0};
			end
		end
	end

	// Stage 2: pairwise sums.
	logic signed [64:0] sa_s2 [3];
	logic signed [64:0] sb_s2 [3];
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int r = 0; r < 3; r++) begin
				sa_s2[r] <= 65'(prod_s1[r][0]) + 65'(prod_s1[r][1]);
				sb_s2[r] <= 65'(prod_s1[r][2]) + 65'(prod_s1[r][3]);
			end
		end
	end

	// Stage 3: final sum, round half up to Q34.16.
	logic signed [65:0]       tot [3];
	logic signed [RoundW-1:0] hom_s3 [3];
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			tot[r] = (66'(sa_s2[r]) + 66'(sb_s2[r]) + 66'sd32768) >>> 16;
		end
	end
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int r = 0; r < 3; r++) hom_s3[r] <= tot[r][RoundW-1:0];
		end
	end

	// Prep: saturate the homogeneous outputs, take magnitudes, seed the dividers.
	div_t             prep;
	logic [HomW-1:0]  sat [3];
	logic [2:0]       sat_ovf;
	logic [RoundW-1:0] an_u, an_v;
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sat_ovf[r] = ~((&hom_s3[r][RoundW-1:HomW-1]) | ~(|hom_s3[r][RoundW-1:HomW-1]));
			if (!sat_ovf[r])        sat[r] = hom_s3[r][HomW-1:0];
			else if (hom_s3[r][RoundW-1]) sat[r] = {1'b1, {(HomW-1){1'b0}}};
			else                    sat[r] = {1'b0, {(HomW-1){1'b1}}};
		end
		an_u = hom_s3[0][RoundW-1] ? RoundW'(-hom_s3[0]) : RoundW'(hom_s3[0]);
		an_v = hom_s3[1][RoundW-1] ? RoundW'(-hom_s3[1]) : RoundW'(hom_s3[1]);
		prep.hom_u   = sat[0];
		prep.hom_v   = sat[1];
		prep.hom_w   = sat[2];
		prep.hom_ovf = |sat_ovf;
		prep.zero    = (hom_s3[2] == '0);
		prep.neg_u   = hom_s3[0][RoundW-1] ^ hom_s3[2][RoundW-1];
		prep.neg_v   = hom_s3[1][RoundW-1] ^ hom_s3[2][RoundW-1];
		prep.ad      = hom_s3[2][RoundW-1] ? RoundW'(-hom_s3[2]) : RoundW'(hom_s3[2]);
		// Integer part of the quotient would not fit in 16 bits.
		prep.big_u   = {16'h0, an_u} >= {prep.ad, 16'h0};
		prep.big_v   = {16'h0, an_v} >= {prep.ad, 16'h0};
		prep.rem_u   = RoundW'(an_u[RoundW-1:16]);
		prep.rem_v   = RoundW'(an_v[RoundW-1:16]);
		prep.q_u     = '0;
		prep.q_v     = '0;
		prep.bits_u  = {an_u[15:0], 16'h0};
		prep.bits_v  = {an_v[15:0], 16'h0};
	end

	div_t dp_s [DivStages+1];
	div_t dnext [DivStages+1];
	always_comb begin
		logic [RoundW:0] tu, tv;
		dnext[0] = prep;
		for (int k = 1; k <= DivStages; k++) begin
			dnext[k] = dp_s[k-1];
			for (int j = 0; j < StepsPerStage; j++) begin
				tu = {dnext[k].rem_u, dnext[k].bits_u[DivSteps-1]};
				tv = {dnext[k].rem_v, dnext[k].bits_v[DivSteps-1]};
				dnext[k].bits_u = {dnext[k].bits_u[DivSteps-2:0], 1'b0};
				dnext[k].bits_v = {dnext[k].bits_v[DivSteps-2:0], 1'b0};
				if (tu >= {1'b0, dnext[k].ad}) begin
					tu = tu - {1'b0, dnext[k].ad};
					dnext[k].q_u = {dnext[k].q_u[DivSteps-2:0], 1'b1};
				end else begin
					dnext[k].q_u = {dnext[k].q_u[DivSteps-2:0], 1'b0};
				end
				if (tv >= {1'b0, dnext[k].ad}) begin
					tv = tv - {1'b0, dnext[k].ad};
					dnext[k].q_v = {dnext[k].q_v[DivSteps-2:0], 1'b1};
				end else begin
					dnext[k].q_v = {dnext[k].q_v[DivSteps-2:0], 1'b0};
				end
				dnext[k].rem_u = tu[RoundW-1:0];
				dnext[k].rem_v = tv[RoundW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k <= DivStages; k++) begin
			if (adv[DivBase+k]) dp_s[k] <= dnext[k];
		end
	end

	// Output: sign, saturate, zero-depth override.
	div_t            fin;
	logic [31:0]     lim_u, lim_v, mag_u, mag_v;
	logic            ovf_u, ovf_v;
	result_t         res;
	always_comb begin
		fin   = dp_s[DivStages];
		lim_u = fin.neg_u ? 32'h8000_0000 : 32'h7FFF_FFFF;
		lim_v = fin.neg_v ? 32'h8000_0000 : 32'h7FFF_FFFF;
		ovf_u = fin.big_u | (fin.q_u > lim_u);
		ovf_v = fin.big_v | (fin.q_v > lim_v);
		mag_u = ovf_u ? lim_u : fin.q_u;
		mag_v = ovf_v ? lim_v : fin.q_v;
		res.hom_u = fin.hom_u;
		res.hom_v = fin.hom_v;
		res.hom_w = fin.hom_w;
		res.zero_depth = fin.zero;
		if (fin.zero) begin
			res.proj_u   = '0;
			res.proj_v   = '0;
			res.overflow = fin.hom_ovf;
		end else begin
			res.proj_u   = fin.neg_u ? -mag_u : mag_u;
			res.proj_v   = fin.neg_v ? -mag_v : mag_v;
			res.overflow = fin.hom_ovf | ovf_u | ovf_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[OutIdx]) result <= res;
	end

endmodule
